// ===== src/cab_pkg.sv =====
package cab_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_PUT     = 2'd1,
      OP_GET     = 2'd2,
      OP_RELEASE = 2'd3
   } cab_op_type;

   // Response error codes
   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_NO_FREE   = 2'd1,
      ERR_UNDERFLOW = 2'd2,
      ERR_OVERFLOW  = 2'd3
   } cab_err_type;

   // Register index, taken from paddr bit 2
   typedef enum logic {
      CSR_MESSAGE_BASE = 1'b0,
      CSR_MESSAGE_SIZE = 1'b1
   } cab_csr_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_MUL,
      ST_SUM
   } cab_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic mul;
      logic load_out;
   } cab_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } cab_status_type;

endpackage

// ===== src/cab_req_if.sv =====
interface cab_req_if #(
   parameter int IDX_W = 3
);
   logic             valid;
   logic             ready;
   logic [1:0]       operation;
   logic [IDX_W-1:0] buffer_index;

   modport source (output valid, output operation, output buffer_index, input ready);
   modport sink   (input valid, input operation, input buffer_index, output ready);
endinterface

// ===== src/cab_rsp_if.sv =====
interface cab_rsp_if #(
   parameter int IDX_W = 3
);
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] result_index;
   logic [31:0]      message_address;
   logic [1:0]       error_code;

   modport source (output valid, output result_index, output message_address,
                   output error_code, input ready);
   modport sink   (input valid, input result_index, input message_address,
                   input error_code, output ready);
endinterface

// ===== src/cab_ram.sv =====
module cab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cab_ctrl.sv =====
module cab_ctrl
   import cab_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cab_status_type status,
   output cab_cmd_type    cmd
);

   cab_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request: capture, table read, update, scale, offset
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // hold until the output register can take the response
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/cab_dpath.sv =====
module cab_dpath
   import cab_pkg::*;
#(
   parameter int NUM_BUFFERS  = 8,
   parameter int COUNT_WIDTH  = 8,
   localparam int IDX_W       = $clog2(NUM_BUFFERS),
   localparam int CNT_W       = $clog2(NUM_BUFFERS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  cab_cmd_type         cmd,
   output cab_status_type      status,
   input  logic [1:0]          req_operation,
   input  logic [IDX_W-1:0]    req_buffer_index,
   input  logic [ADDR_W-1:0]   message_base,
   input  logic [SIZE_W-1:0]   message_size,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [IDX_W-1:0]    rsp_result_index,
   output logic [ADDR_W-1:0]   rsp_message_address,
   output logic [1:0]          rsp_error_code
);

   localparam int PROD_W = IDX_W + SIZE_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [CNT_W-1:0]       NUM_CNT   = CNT_W'(NUM_BUFFERS);

   // Captured request
   cab_op_type       op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W:0]   idx_wide;

   // Manager state
   logic [CNT_W-1:0]       free_count_ff, free_count_in;
   logic [CNT_W-1:0]       low_ff, low_in;
   logic [IDX_W-1:0]       most_recent_ff, most_recent_in;
   logic [NUM_BUFFERS-1:0] rc_valid_ff, rc_valid_in;

   // Result pipeline
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   cab_err_type       err_ff, err_in;
   logic              zero_ff, zero_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   cab_err_type       rsp_err_ff;

   // Memory ports
   logic                   fs_we;
   logic [IDX_W-1:0]       fs_wdata, fs_rdata, fs_raddr, fs_val;
   logic                   rc_we;
   logic [IDX_W-1:0]       rc_addr;
   logic [COUNT_WIDTH-1:0] rc_wdata, rc_rdata, rc_val;
   logic                   push_en;
   logic [IDX_W-1:0]       push_idx;

   // Free stack and reader count tables
   cab_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_free_stack (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (free_count_ff[IDX_W-1:0]),
      .wr_data (fs_wdata),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

   cab_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BUFFERS)) u_reader_count (
      .clock   (clock),
      .wr_en   (rc_we),
      .wr_addr (rc_addr),
      .wr_data (rc_wdata),
      .rd_addr (rc_addr),
      .rd_data (rc_rdata)
   );

   // Read the stack top and the counter of the addressed buffer
   assign fs_raddr = IDX_W'(free_count_ff - CNT_W'(1));
   assign rc_addr  = (op_ff == OP_RELEASE) ? idx_ff : most_recent_ff;

   // Stack slots below the low-water mark were never written since reset
   assign fs_val = (low_ff == free_count_ff) ? fs_raddr : fs_rdata;
   assign rc_val = rc_valid_ff[rc_addr] ? rc_rdata : '0;

   // Fold an out-of-range index back into the buffer range
   assign idx_wide = {1'b0, req_buffer_index};

   always_comb begin
      op_in  = op_ff;
      idx_in = idx_ff;
      if (cmd.capture) begin
         op_in = cab_op_type'(req_operation);
         if (idx_wide >= (IDX_W + 1)'(NUM_BUFFERS)) begin
            idx_in = IDX_W'(idx_wide - (IDX_W + 1)'(NUM_BUFFERS));
         end else begin
            idx_in = req_buffer_index;
         end
      end
   end

   // Apply the operation to the manager state
   always_comb begin
      free_count_in  = free_count_ff;
      low_in         = low_ff;
      most_recent_in = most_recent_ff;
      rc_valid_in    = rc_valid_ff;
      res_idx_in     = res_idx_ff;
      err_in         = err_ff;
      zero_in        = zero_ff;
      fs_we          = 1'b0;
      fs_wdata       = most_recent_ff;
      rc_we          = 1'b0;
      rc_wdata       = rc_val;
      push_en        = 1'b0;
      push_idx       = most_recent_ff;
      if (cmd.exec) begin
         res_idx_in = idx_ff;
         err_in     = ERR_OK;
         zero_in    = 1'b0;
         unique case (op_ff)
            OP_RESERVE: begin
               if (free_count_ff == '0) begin
                  err_in     = ERR_NO_FREE;
                  res_idx_in = '0;
                  zero_in    = 1'b1;
               end else begin
                  free_count_in = free_count_ff - CNT_W'(1);
                  res_idx_in    = fs_val;
                  if (low_ff == free_count_ff) begin
                     low_in = free_count_ff - CNT_W'(1);
                  end
               end
            end
            OP_PUT: begin
               // free the old most recent buffer when nobody reads it
               push_en        = (rc_val == '0);
               push_idx       = most_recent_ff;
               most_recent_in = idx_ff;
            end
            OP_GET: begin
               res_idx_in = most_recent_ff;
               if (rc_val == COUNT_MAX) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  rc_we                = 1'b1;
                  rc_wdata             = rc_val + COUNT_WIDTH'(1);
                  rc_valid_in[rc_addr] = 1'b1;
               end
            end
            OP_RELEASE: begin
               if (rc_val == '0) begin
                  err_in = ERR_UNDERFLOW;
               end else begin
                  rc_we                = 1'b1;
                  rc_wdata             = rc_val - COUNT_WIDTH'(1);
                  rc_valid_in[rc_addr] = 1'b1;
                  push_en  = (rc_val == COUNT_WIDTH'(1)) && (idx_ff != most_recent_ff);
                  push_idx = idx_ff;
               end
            end
            default: begin
               err_in = ERR_OK;
            end
         endcase
         // drop the push when the stack is already full
         if (push_en && (free_count_ff < NUM_CNT)) begin
            fs_we         = 1'b1;
            fs_wdata      = push_idx;
            free_count_in = free_count_ff + CNT_W'(1);
         end
      end
   end

   // Scale the index by the message size
   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul) begin
         prod_in = PROD_W'(res_idx_ff) * PROD_W'(message_size);
      end
   end

   // Offset by the base and load the output register
   assign rsp_addr_in = zero_ff ? '0 : message_base + ADDR_W'(prod_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff  <= CNT_W'(NUM_BUFFERS - 1);
         low_ff         <= CNT_W'(NUM_BUFFERS - 1);
         most_recent_ff <= IDX_W'(NUM_BUFFERS - 1);
         rc_valid_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         free_count_ff  <= free_count_in;
         low_ff         <= low_in;
         most_recent_ff <= most_recent_in;
         rc_valid_ff    <= rc_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      res_idx_ff <= res_idx_in;
      err_ff     <= err_in;
      zero_ff    <= zero_in;
      prod_ff    <= prod_in;
      if (cmd.load_out) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_addr_ff <= rsp_addr_in;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_index    = rsp_idx_ff;
   assign rsp_message_address = rsp_addr_ff;
   assign rsp_error_code      = rsp_err_ff;

   a_free_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= NUM_CNT)
      else $error("free count above buffer count");

   a_low_water: assert property (@(posedge clock) disable iff (reset)
      low_ff <= free_count_ff)
      else $error("low-water mark above free count");

   a_most_recent_range: assert property (@(posedge clock) disable iff (reset)
      most_recent_ff < IDX_W'(NUM_BUFFERS - 1) || most_recent_ff == IDX_W'(NUM_BUFFERS - 1))
      else $error("most recent index out of range");

   a_reserve_pops: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_RESERVE && free_count_ff != '0)
      |=> free_count_ff == $past(free_count_ff) - CNT_W'(1))
      else $error("reserve did not pop the free stack");

endmodule

// ===== src/cyclic_async_buffer_manager_top.sv =====
// Channel  Direction  Handshake      Payload
// req_bus  in         valid/ready    operation, buffer_index
// rsp_bus  out        valid/ready    result_index, message_address, error_code
// csr_*    in/out     APB, pready=1  message_base @0x0, message_size @0x4
//
// One request at a time: after accept the request passes capture, table read,
// update, scale by size and add base before the response is loaded; the next
// request is accepted only once the controller is back in idle.
// The registered read of the free stack and reader count tables sets the
// read cycle; the response register frees the core while a result waits.
// A stalled response holds the last cycle until rsp_bus.ready frees it.
// Synchronous reset: buffer N-1 is most recent, N-1 buffers free, no readers.
module cyclic_async_buffer_manager_top
   import cab_pkg::*;
#(
   parameter int NUM_BUFFERS = 8,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   cab_req_if.sink               req_bus,
   cab_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              csr_write;
   cab_csr_type       csr_sel;
   cab_cmd_type       cmd;
   cab_status_type    status;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = cab_csr_type'(csr_paddr[2]);

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_write) begin
         unique case (csr_sel)
            CSR_MESSAGE_BASE: base_in = csr_pwdata;
            CSR_MESSAGE_SIZE: size_in = csr_pwdata[SIZE_W-1:0];
            default:          base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= SIZE_W'(1);
      end else begin
         base_ff <= base_in;
         size_ff <= size_in;
      end
   end

   // Read back the selected register
   always_comb begin
      unique case (csr_sel)
         CSR_MESSAGE_BASE: csr_prdata = base_ff;
         CSR_MESSAGE_SIZE: csr_prdata = CSR_DATA_W'(size_ff);
         default:          csr_prdata = '0;
      endcase
   end

   cab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cab_dpath #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_bus.operation),
      .req_buffer_index    (req_bus.buffer_index),
      .message_base        (base_ff),
      .message_size        (size_ff),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_result_index    (rsp_bus.result_index),
      .rsp_message_address (rsp_bus.message_address),
      .rsp_error_code      (rsp_bus.error_code)
   );

endmodule

// ===== tb/cab_result_checker.sv =====
module cab_result_checker
   import cab_pkg::*;
#(
   parameter int NUM_BUFFERS = 8,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   cab_req_if                    req_mon,
   cab_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int unsigned           fail_count,
   output int unsigned           pending_count
);

   localparam int IDX_W = $clog2(NUM_BUFFERS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [31:0]      address;
      cab_err_type      err;
   } buffer_result_type;

   // Shadow of the buffer manager
   logic [IDX_W-1:0]       free_list [NUM_BUFFERS];
   int unsigned            free_depth;
   logic [IDX_W-1:0]       newest_buffer;
   logic [COUNT_WIDTH-1:0] readers [NUM_BUFFERS];
   logic [ADDR_W-1:0]      msg_base;
   logic [SIZE_W-1:0]      msg_size;

   buffer_result_type awaited_results[$];
   int unsigned       mismatches = 0;

   function automatic logic [31:0] buffer_address(logic [IDX_W-1:0] idx);
      return msg_base + 32'(idx) * 32'(msg_size);
   endfunction

   // Push a buffer back; a full stack drops it
   function automatic void free_buffer(logic [IDX_W-1:0] idx);
      if (free_depth < NUM_BUFFERS) begin
         free_list[free_depth] = idx;
         free_depth++;
      end
   endfunction

   function automatic buffer_result_type serve_request(cab_op_type op,
                                                       logic [IDX_W-1:0] raw_idx);
      buffer_result_type res;
      logic [IDX_W-1:0]  idx;
      idx = IDX_W'(raw_idx % NUM_BUFFERS);
      res = '{index: '0, address: '0, err: ERR_OK};
      case (op)
         OP_RESERVE: begin
            // empty stack reports zero index and address
            if (free_depth == 0) begin
               res.err = ERR_NO_FREE;
            end else begin
               free_depth--;
               res.index   = free_list[free_depth];
               res.address = buffer_address(res.index);
            end
         end
         OP_PUT: begin
            // old message goes back unless someone still reads it
            if (readers[newest_buffer] == 0) free_buffer(newest_buffer);
            newest_buffer = idx;
            res.index     = idx;
            res.address   = buffer_address(idx);
         end
         OP_GET: begin
            res.index   = newest_buffer;
            res.address = buffer_address(newest_buffer);
            if (readers[newest_buffer] == COUNT_MAX) res.err = ERR_OVERFLOW;
            else readers[newest_buffer]++;
         end
         default: begin
            res.index   = idx;
            res.address = buffer_address(idx);
            if (readers[idx] == 0) begin
               res.err = ERR_UNDERFLOW;
            end else begin
               readers[idx]--;
               if (readers[idx] == 0 && idx != newest_buffer) free_buffer(idx);
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      buffer_result_type want;
      if (reset) begin
         // last buffer holds the newest message, the rest are free
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            free_list[i] = (i < NUM_BUFFERS - 1) ? IDX_W'(i) : '0;
            readers[i]   = '0;
         end
         free_depth    = NUM_BUFFERS - 1;
         newest_buffer = IDX_W'(NUM_BUFFERS - 1);
         msg_base      = '0;
         msg_size      = SIZE_W'(1);
         awaited_results.delete();
      end else begin
         // compare each response against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response with no request outstanding: index %0d",
                      rsp_mon.result_index);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.result_index !== want.index) begin
                  $error("result_index: expected %0d, got %0d",
                         want.index, rsp_mon.result_index);
                  mismatches++;
               end
               if (rsp_mon.message_address !== want.address) begin
                  $error("message_address: expected %h, got %h",
                         want.address, rsp_mon.message_address);
                  mismatches++;
               end
               if (rsp_mon.error_code !== want.err) begin
                  $error("error_code: expected %0d, got %0d",
                         want.err, rsp_mon.error_code);
                  mismatches++;
               end
            end
         end
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (cab_csr_type'(csr_paddr[2]))
               CSR_MESSAGE_BASE: msg_base = csr_pwdata;
               CSR_MESSAGE_SIZE: msg_size = csr_pwdata[SIZE_W-1:0];
            endcase
         end
         // predict the response of each accepted request
         if (req_mon.valid && req_mon.ready) begin
            awaited_results.push_back(serve_request(cab_op_type'(req_mon.operation),
                                                    req_mon.buffer_index));
         end
      end
      fail_count    <= mismatches;
      pending_count <= awaited_results.size();
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import cab_pkg::*;

   localparam int NUM_BUFFERS = 8;
   localparam int COUNT_WIDTH = 8;
   localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
   localparam int LONG_HOLD   = 200;
   localparam int PHASE_ITEMS = 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           fail_count;
   int unsigned           pending_count;

   // Requests in flight and buffers the traffic currently owns
   cab_op_type  sent_ops[$];
   logic [2:0]  reserved_bufs[$];
   logic [2:0]  read_bufs[$];
   bit          gaps_on = 1'b1;
   bit          hold_off_req = 1'b0;

   cab_req_if req_bus();
   cab_rsp_if rsp_bus();

   cyclic_async_buffer_manager_top #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   cab_result_checker #(
      .NUM_BUFFERS(NUM_BUFFERS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one request after a random gap, hold it until accepted
   task automatic send_request(cab_op_type op, logic [2:0] idx);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= op;
      req_bus.buffer_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      sent_ops.push_back(op);
   endtask

   // Mostly writer and reader sequences, with some noise
   task automatic send_random_item();
      int unsigned pick;
      int unsigned k;
      logic [2:0]  idx;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         send_request(cab_op_type'($urandom_range(0, 3)), 3'($urandom));
      end else if (pick < 50 && reserved_bufs.size() != 0) begin
         send_request(OP_PUT, reserved_bufs.pop_front());
      end else if (pick < 75 && read_bufs.size() != 0) begin
         k   = $urandom_range(0, read_bufs.size() - 1);
         idx = read_bufs[k];
         read_bufs.delete(k);
         send_request(OP_RELEASE, idx);
      end else if (pick < 88) begin
         send_request(OP_RESERVE, 3'($urandom));
      end else begin
         send_request(OP_GET, 3'($urandom));
      end
   endtask

   // Setup phase, access phase, then idle with psel low
   task automatic write_register(cab_csr_type which, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait for every response to drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Response side: random stalls, one long hold-off on request
   initial begin
      int unsigned stall;
      cab_op_type  op;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_req) begin
            stall        = LONG_HOLD;
            hold_off_req = 1'b0;
         end else begin
            stall = gaps_on ? $urandom_range(0, 15) : 0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         // remember owned buffers for later puts and releases
         op = sent_ops.pop_front();
         if (rsp_bus.error_code == ERR_OK) begin
            if (op == OP_RESERVE) reserved_bufs.push_back(rsp_bus.result_index);
            else if (op == OP_GET) read_bufs.push_back(rsp_bus.result_index);
         end
      end
   end

   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_RESERVE;
      req_bus.buffer_index <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset registers
      send_request(OP_RELEASE, 3'd3);   // release with no readers
      send_request(OP_PUT, 3'd7);       // put newest again, goes to free stack
      send_request(OP_PUT, 3'd7);       // stack already full, push dropped
      repeat (NUM_BUFFERS) send_request(OP_RESERVE, 3'($urandom));
      send_request(OP_RESERVE, 3'd7);   // nothing left to reserve
      send_request(OP_GET, 3'd0);
      send_request(OP_PUT, 3'd5);       // old newest still read, kept
      send_request(OP_RELEASE, 3'd7);   // last reader gone, freed
      send_request(OP_GET, 3'd0);
      send_request(OP_RELEASE, 3'd5);   // idle but newest, kept
      send_request(OP_PUT, 3'd0);
      wait_idle();

      // Directed: largest base and size, address wraps
      write_register(CSR_MESSAGE_BASE, 32'hFFFF_FFFF);
      write_register(CSR_MESSAGE_SIZE, 32'h0000_FFFF);
      send_request(OP_RESERVE, 3'd0);
      send_request(OP_GET, 3'd7);
      send_request(OP_PUT, 3'd7);
      send_request(OP_RELEASE, 3'd0);
      wait_idle();

      // Directed: zero size, every address is the base
      write_register(CSR_MESSAGE_BASE, 32'h8000_0001);
      write_register(CSR_MESSAGE_SIZE, 32'h0000_0000);
      send_request(OP_RESERVE, 3'd0);
      send_request(OP_GET, 3'd0);
      send_request(OP_RELEASE, 3'd7);
      wait_idle();

      // Random phases, each under its own register setting
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0) begin
            write_register(CSR_MESSAGE_BASE, 32'h0);
            write_register(CSR_MESSAGE_SIZE, 32'h1);
         end else begin
            write_register(CSR_MESSAGE_BASE, $urandom);
            write_register(CSR_MESSAGE_SIZE, 32'($urandom_range(0, 65535)));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            // stall the response side while requests keep coming
            if (phase == 1 && n == 10) begin
               gaps_on      = 1'b0;
               hold_off_req = 1'b1;
            end
            send_random_item();
         end
         gaps_on = 1'b1;
         wait_idle();
      end

      // Saturate the reader count of the newest buffer
      gaps_on = 1'b0;
      repeat (COUNT_MAX + 1) send_request(OP_GET, 3'($urandom));
      wait_idle();
      gaps_on = 1'b1;

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/cab_pkg.sv
src/cab_req_if.sv
src/cab_rsp_if.sv
src/cab_ram.sv
src/cab_ctrl.sv
src/cab_dpath.sv
src/cyclic_async_buffer_manager_top.sv
tb/cab_result_checker.sv
tb/testbench.sv
